// ===== design/pfsr_pkg.sv =====
// Package for the preamble sync frame receiver: shared constants, register
// indexes and the structs passed between the receiver modules.
// No dependencies.
`timescale 1ns / 1ps

package pfsr_pkg;

   // Largest frame the payload counter can follow.
   localparam int unsigned MAX_FRAME_BYTES = 65536;

   // Field widths.
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned INDEX_W     = 16;
   localparam int unsigned PREAMBLE_W  = 32;
   localparam int unsigned PRE_LEN_W   = 3;
   localparam int unsigned FRAME_LEN_W = 17;
   localparam int unsigned POS_W       = 2;
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned RSP_DATA_W  = BYTE_W + INDEX_W;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_PREAMBLE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PREAMBLE_LEN = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_BYTES = 2'd2;

   // Register reset values ("peli", four sync bytes, 16*4*318 payload bytes).
   localparam logic [PREAMBLE_W-1:0]  PREAMBLE_RESET    = 32'h7065_6C69;
   localparam logic [PRE_LEN_W-1:0]   PREAMBLE_LEN_RESET = 3'd4;
   localparam logic [FRAME_LEN_W-1:0] FRAME_BYTES_RESET = 17'(16 * 4 * 318);

   // Largest effective preamble and frame lengths.
   localparam logic [PRE_LEN_W-1:0]   PRE_LEN_MAX   = 3'd4;
   localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_MAX = FRAME_LEN_W'(MAX_FRAME_BYTES);

   // Effective configuration, already clamped to legal ranges.
   typedef struct packed {
      logic [PREAMBLE_W-1:0]  preamble;
      logic [PRE_LEN_W-1:0]   pre_len;
      logic [FRAME_LEN_W-1:0] frame_len;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [BYTE_W-1:0]  payload_byte;
      logic [INDEX_W-1:0] byte_index;
      logic               last_of_frame;
   } result_type;

   // Tracker status seen by the top level.
   typedef struct packed {
      logic receiving;
      logic result_valid;
   } status_type;

endpackage

// ===== design/pfsr_csr.sv =====
// Configuration registers of the frame receiver and the clamping of the
// lengths to their effective ranges. Depends on pfsr_pkg.
`timescale 1ns / 1ps

module pfsr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pfsr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pfsr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output pfsr_pkg::cfg_type                   cfg
);

   logic [pfsr_pkg::PREAMBLE_W-1:0]  preamble_ff,  preamble_in;
   logic [pfsr_pkg::PRE_LEN_W-1:0]   pre_len_ff,   pre_len_in;
   logic [pfsr_pkg::FRAME_LEN_W-1:0] frame_len_ff, frame_len_in;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      preamble_in  = preamble_ff;
      pre_len_in   = pre_len_ff;
      frame_len_in = frame_len_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pfsr_pkg::CSR_PREAMBLE:     preamble_in = csr_wdata;
            pfsr_pkg::CSR_PREAMBLE_LEN: pre_len_in  = csr_wdata[pfsr_pkg::PRE_LEN_W-1:0];
            pfsr_pkg::CSR_FRAME_BYTES:  frame_len_in = csr_wdata[pfsr_pkg::FRAME_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff  <= pfsr_pkg::PREAMBLE_RESET;
         pre_len_ff   <= pfsr_pkg::PREAMBLE_LEN_RESET;
         frame_len_ff <= pfsr_pkg::FRAME_BYTES_RESET;
      end else begin
         preamble_ff  <= preamble_in;
         pre_len_ff   <= pre_len_in;
         frame_len_ff <= frame_len_in;
      end
   end

   // Zero lengths count as one; lengths above the maximum saturate.
   always_comb begin
      cfg.preamble = preamble_ff;
      if (pre_len_ff == '0) begin
         cfg.pre_len = pfsr_pkg::PRE_LEN_W'(1);
      end else if (pre_len_ff > pfsr_pkg::PRE_LEN_MAX) begin
         cfg.pre_len = pfsr_pkg::PRE_LEN_MAX;
      end else begin
         cfg.pre_len = pre_len_ff;
      end
      if (frame_len_ff == '0) begin
         cfg.frame_len = pfsr_pkg::FRAME_LEN_W'(1);
      end else if (frame_len_ff > pfsr_pkg::FRAME_LEN_MAX) begin
         cfg.frame_len = pfsr_pkg::FRAME_LEN_MAX;
      end else begin
         cfg.frame_len = frame_len_ff;
      end
   end

endmodule

// ===== design/pfsr_tracker.sv =====
// Hunt/receive tracker: matches the preamble byte by byte, then numbers the
// payload bytes of one frame. Depends on pfsr_pkg.
`timescale 1ns / 1ps

module pfsr_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  pfsr_pkg::cfg_type               cfg,
   input  logic                            in_fire,
   input  logic [pfsr_pkg::BYTE_W-1:0]     rx_byte,
   output pfsr_pkg::result_type            result,
   output pfsr_pkg::status_type            status
);

   logic                             receiving_ff, receiving_in;
   logic [pfsr_pkg::POS_W-1:0]       match_pos_ff, match_pos_in;
   logic [pfsr_pkg::INDEX_W-1:0]     count_ff,     count_in;
   logic [pfsr_pkg::BYTE_W-1:0]      expected;
   logic                             pre_done;
   logic                             frame_done;

   // Expected sync byte at the current match position, first byte on top.
   always_comb begin
      unique case (match_pos_ff)
         2'd0:    expected = cfg.preamble[31:24];
         2'd1:    expected = cfg.preamble[23:16];
         2'd2:    expected = cfg.preamble[15:8];
         default: expected = cfg.preamble[7:0];
      endcase
   end

   assign pre_done   = ({1'b0, match_pos_ff} + pfsr_pkg::PRE_LEN_W'(1)) >= cfg.pre_len;
   assign frame_done = ({1'b0, count_ff} + pfsr_pkg::FRAME_LEN_W'(1)) >= cfg.frame_len;

   // Result for a byte taken in receive mode.
   assign result.payload_byte  = rx_byte;
   assign result.byte_index    = count_ff;
   assign result.last_of_frame = frame_done;
   assign status.receiving     = receiving_ff;
   assign status.result_valid  = receiving_ff;

   // State update on each input transfer.
   always_comb begin
      receiving_in = receiving_ff;
      match_pos_in = match_pos_ff;
      count_in     = count_ff;
      if (in_fire) begin
         if (!receiving_ff) begin
            if (rx_byte == expected) begin
               if (pre_done) begin
                  match_pos_in = '0;
                  receiving_in = 1'b1;
                  count_in     = '0;
               end else begin
                  match_pos_in = match_pos_ff + pfsr_pkg::POS_W'(1);
               end
            end else begin
               match_pos_in = '0;
            end
         end else if (frame_done) begin
            receiving_in = 1'b0;
            count_in     = '0;
            match_pos_in = '0;
         end else begin
            count_in = count_ff + pfsr_pkg::INDEX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         match_pos_ff <= '0;
         count_ff     <= '0;
      end else begin
         receiving_ff <= receiving_in;
         match_pos_ff <= match_pos_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ===== design/pfsr_out_reg.sv =====
// Result register between the tracker and the result channel; holds one
// result while the consumer stalls. Depends on pfsr_pkg.
`timescale 1ns / 1ps

module pfsr_out_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  pfsr_pkg::result_type        result,
   output logic                        out_valid,
   input  logic                        out_ready,
   output pfsr_pkg::result_type        out_data,
   output logic                        can_take
);

   logic                  valid_ff, valid_in;
   pfsr_pkg::result_type  data_ff;

   // A new result may enter when the register is empty or drains this cycle.
   assign can_take = !valid_ff || out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/preamble_sync_frame_receiver_core.sv =====
// Top level of the preamble sync frame receiver: configuration registers,
// hunt/receive tracker and result register. Depends on pfsr_pkg and submodules.
//
//   Channel   Direction  Handshake         Contents
//   req_      in         tvalid/tready     tdata[7:0] rx_byte
//   rsp_      out        tvalid/tready     tdata: payload_byte, byte_index; tlast
//   csr_      in         we (no wait)      addr selects register, wdata value
//
// One byte is taken per cycle; a payload byte shows on rsp_ in the cycle after
// its transfer, held in a single result register. Hunting bytes give no result.
// req_tready drops only while that register is full and rsp_tready is low.
// Reset is synchronous: the receiver starts hunting with the default registers.
`timescale 1ns / 1ps

module preamble_sync_frame_receiver_core (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: [7:0] rx_byte
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pfsr_pkg::BYTE_W-1:0]         req_tdata,
   // tdata: [7:0] payload_byte, [23:8] byte_index
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pfsr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [pfsr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pfsr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pfsr_pkg::cfg_type     cfg;
   pfsr_pkg::result_type  result;
   pfsr_pkg::result_type  out_data;
   pfsr_pkg::status_type  status;
   logic                  in_fire;
   logic                  can_take;

   assign req_tready = can_take;
   assign in_fire    = req_tvalid && req_tready;

   pfsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pfsr_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .in_fire (in_fire),
      .rx_byte (req_tdata),
      .result  (result),
      .status  (status)
   );

   pfsr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (in_fire && status.result_valid),
      .result    (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data),
      .can_take  (can_take)
   );

   assign rsp_tdata = {out_data.byte_index, out_data.payload_byte};
   assign rsp_tlast = out_data.last_of_frame;

   // A byte transferred in receive mode always yields a result next cycle.
   a_payload_out: assert property (@(posedge clock) disable iff (reset)
      in_fire && status.receiving |=> rsp_tvalid)
      else $error("payload byte transfer produced no result");

   // Receive mode is entered only on a byte transfer.
   a_enter_on_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(status.receiving) |-> $past(in_fire))
      else $error("receive mode entered without an input transfer");

   // The final payload byte returns the tracker to hunting.
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      in_fire && status.receiving && result.last_of_frame |=> !status.receiving)
      else $error("tracker kept receiving after the last payload byte");

   // The first result of a frame carries index zero.
   a_first_index: assert property (@(posedge clock) disable iff (reset)
      in_fire && $rose(status.receiving) |-> result.byte_index == '0)
      else $error("frame did not start at index zero");

endmodule

// ===== tb/preamble_sync_frame_receiver_core_tb.sv =====
// Self-checking testbench for preamble_sync_frame_receiver_core: preamble hunting,
// fixed-length payload framing and register writes under random flow control.
// Depends on pfsr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module preamble_sync_frame_receiver_core_tb;

   localparam int RANDOM_BYTES   = 1800;
   localparam int LONG_PREFIX    = 24;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic {OP_BYTE, OP_CSR} op_kind_type;

   // One entry of the stimulus: either a received byte or a register write.
   typedef struct packed {
      op_kind_type                          kind;
      logic [pfsr_pkg::CSR_ADDR_W-1:0]      addr;
      logic [pfsr_pkg::CSR_DATA_W-1:0]      wdata;
      logic [pfsr_pkg::BYTE_W-1:0]          rx_byte;
   } link_op_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   // tdata: [7:0] rx_byte
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [pfsr_pkg::BYTE_W-1:0]         req_tdata = '0;
   // tdata: [7:0] payload_byte, [23:8] byte_index
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [pfsr_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                                rsp_tlast;
   logic                                csr_we = 1'b0;
   logic [pfsr_pkg::CSR_ADDR_W-1:0]     csr_addr = '0;
   logic [pfsr_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   link_op_type          link_ops[$];
   pfsr_pkg::result_type expected_payload[$];

   // Register shadows: one for building the stimulus, one for tracking the block.
   pfsr_pkg::cfg_type gen_cfg;
   pfsr_pkg::cfg_type live_cfg;

   // Tracked receiver state.
   logic                             rx_receiving;
   logic [pfsr_pkg::POS_W-1:0]       rx_match_pos;
   logic [pfsr_pkg::INDEX_W-1:0]     rx_count;

   int burst_left;
   int gap_left;
   int quiet_cycles;
   int stall_left;
   int stall_mode;
   int idle_cycles;
   int error_count = 0;
   int queued_bytes = 0;

   preamble_sync_frame_receiver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Effective preamble length: zero counts as one, anything above four as four.
   function automatic int sync_len(input logic [pfsr_pkg::PRE_LEN_W-1:0] n);
      if (n == 0) return 1;
      if (n > pfsr_pkg::PRE_LEN_MAX) return int'(pfsr_pkg::PRE_LEN_MAX);
      return int'(n);
   endfunction

   // Effective frame length: zero counts as one, large values saturate.
   function automatic int frame_len(input logic [pfsr_pkg::FRAME_LEN_W-1:0] n);
      if (n == 0) return 1;
      if (n > pfsr_pkg::FRAME_LEN_MAX) return int'(pfsr_pkg::MAX_FRAME_BYTES);
      return int'(n);
   endfunction

   function automatic logic [pfsr_pkg::BYTE_W-1:0] sync_byte(input pfsr_pkg::cfg_type c,
                                                             input int pos);
      return c.preamble[31 - 8 * pos -: 8];
   endfunction

   function automatic pfsr_pkg::cfg_type with_write(
         input pfsr_pkg::cfg_type c,
         input logic [pfsr_pkg::CSR_ADDR_W-1:0] addr,
         input logic [pfsr_pkg::CSR_DATA_W-1:0] data);
      pfsr_pkg::cfg_type r;
      r = c;
      case (addr)
         pfsr_pkg::CSR_PREAMBLE:     r.preamble  = data;
         pfsr_pkg::CSR_PREAMBLE_LEN: r.pre_len   = data[pfsr_pkg::PRE_LEN_W-1:0];
         pfsr_pkg::CSR_FRAME_BYTES:  r.frame_len = data[pfsr_pkg::FRAME_LEN_W-1:0];
         default: ;
      endcase
      return r;
   endfunction

   // Follow one accepted byte through hunt or receive mode.
   task automatic track_byte(input logic [pfsr_pkg::BYTE_W-1:0] b);
      pfsr_pkg::result_type r;
      int pos;
      pos = int'(rx_match_pos);
      if (!rx_receiving) begin
         if (b == sync_byte(live_cfg, pos)) begin
            if (pos + 1 >= sync_len(live_cfg.pre_len)) begin
               rx_match_pos = '0;
               rx_receiving = 1'b1;
               rx_count = '0;
            end else begin
               rx_match_pos = rx_match_pos + 1'b1;
            end
         end else begin
            // A mismatching byte is dropped, not tried again as a first sync byte.
            rx_match_pos = '0;
         end
      end else begin
         r.payload_byte  = b;
         r.byte_index    = rx_count;
         r.last_of_frame = (int'(rx_count) + 1 >= frame_len(live_cfg.frame_len));
         expected_payload.push_back(r);
         if (r.last_of_frame) begin
            rx_receiving = 1'b0;
            rx_count = '0;
            rx_match_pos = '0;
         end else begin
            rx_count = rx_count + 1'b1;
         end
      end
   endtask

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endtask

   task automatic push_byte(input logic [pfsr_pkg::BYTE_W-1:0] b);
      link_op_type op;
      op = '{kind: OP_BYTE, addr: '0, wdata: '0, rx_byte: b};
      link_ops.push_back(op);
      queued_bytes++;
   endtask

   task automatic push_csr(input logic [pfsr_pkg::CSR_ADDR_W-1:0] addr,
                           input logic [pfsr_pkg::CSR_DATA_W-1:0] data);
      link_op_type op;
      op = '{kind: OP_CSR, addr: addr, wdata: data, rx_byte: '0};
      link_ops.push_back(op);
      gen_cfg = with_write(gen_cfg, addr, data);
   endtask

   // The full preamble as the registers currently define it.
   task automatic push_sync();
      for (int i = 0; i < sync_len(gen_cfg.pre_len); i++) push_byte(sync_byte(gen_cfg, i));
   endtask

   function automatic logic [pfsr_pkg::PREAMBLE_W-1:0] pick_preamble();
      logic [7:0] a;
      logic [7:0] b;
      a = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(0, 2))
         0: return $urandom;
         1: return {4{a}};
         default: return {a, a, b, a};
      endcase
   endfunction

   function automatic logic [pfsr_pkg::FRAME_LEN_W-1:0] pick_frame();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return pfsr_pkg::FRAME_LEN_W'($urandom_range(13, 200));
         default: return pfsr_pkg::FRAME_LEN_W'($urandom_range(1, 12));
      endcase
   endfunction

   // Driver: feeds bytes in random bursts and applies register writes once idle.
   always @(posedge clock) begin : drive_proc
      link_op_type op;
      logic free;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         csr_we <= 1'b0;
         csr_addr <= '0;
         csr_wdata <= '0;
         burst_left = 0;
         gap_left = 0;
         quiet_cycles = 0;
         live_cfg = '{pfsr_pkg::PREAMBLE_RESET, pfsr_pkg::PREAMBLE_LEN_RESET,
                      pfsr_pkg::FRAME_BYTES_RESET};
         rx_receiving = 1'b0;
         rx_match_pos = '0;
         rx_count = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_byte(req_tdata);
            quiet_cycles = 0;
         end else if (expected_payload.size() != 0) begin
            quiet_cycles = 0;
         end else if (quiet_cycles < WATCHDOG_LIMIT) begin
            quiet_cycles++;
         end
         free = !req_tvalid || req_tready;
         if (!free || link_ops.size() == 0) begin
            if (free) req_tvalid <= 1'b0;
            csr_we <= 1'b0;
         end else if (link_ops[0].kind == OP_CSR) begin
            req_tvalid <= 1'b0;
            // Hunting bytes give no result, so wait out the pipeline before writing.
            if (quiet_cycles >= SETTLE_CYCLES) begin
               op = link_ops.pop_front();
               csr_we <= 1'b1;
               csr_addr <= op.addr;
               csr_wdata <= op.wdata;
               live_cfg = with_write(live_cfg, op.addr, op.wdata);
            end else begin
               csr_we <= 1'b0;
            end
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
            csr_we <= 1'b0;
         end else begin
            op = link_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= op.rx_byte;
            csr_we <= 1'b0;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Monitor: stalls the result channel and checks every result transfer.
   always @(posedge clock) begin : check_proc
      pfsr_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         stall_mode = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_payload.size() == 0) begin
               flag_error($sformatf("unexpected result: byte %02h index %0d last %0b",
                                    rsp_tdata[7:0], rsp_tdata[23:8], rsp_tlast));
            end else begin
               want = expected_payload.pop_front();
               if (rsp_tdata[7:0] != want.payload_byte)
                  flag_error($sformatf("payload_byte: expected %02h, got %02h",
                                       want.payload_byte, rsp_tdata[7:0]));
               if (rsp_tdata[23:8] != want.byte_index)
                  flag_error($sformatf("byte_index: expected %0d, got %0d",
                                       want.byte_index, rsp_tdata[23:8]));
               if (rsp_tlast !== want.last_of_frame)
                  flag_error($sformatf("last_of_frame at index %0d: expected %0b, got %0b",
                                       want.byte_index, want.last_of_frame, rsp_tlast));
            end
         end
         if (stall_left == 0) begin
            stall_left = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 3);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            2: rsp_tready <= 1'($urandom_range(0, 1));
            3: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // Watchdog: ends the run when no transfer and no write happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int first_random;
      int k;
      int len;
      logic [pfsr_pkg::BYTE_W-1:0] b;

      gen_cfg = '{pfsr_pkg::PREAMBLE_RESET, pfsr_pkg::PREAMBLE_LEN_RESET,
                  pfsr_pkg::FRAME_BYTES_RESET};

      // Default sync word with a false start; the repeated first byte is dropped.
      push_byte(8'h70);
      push_byte(8'h70);
      push_byte(8'h65);
      push_byte(8'h6C);
      push_byte(8'h69);
      push_sync();
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'hA5);
      // Shortening the frame below the current count ends it on the next byte.
      push_csr(pfsr_pkg::CSR_FRAME_BYTES, 32'd2);
      push_byte(8'h5A);

      // Zero preamble length and zero frame length both act as one.
      push_csr(pfsr_pkg::CSR_PREAMBLE, 32'hFF00_0000);
      push_csr(pfsr_pkg::CSR_PREAMBLE_LEN, 32'd0);
      push_csr(pfsr_pkg::CSR_FRAME_BYTES, 32'd0);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(8'h33);

      // Preamble lengths above four act as four.
      push_csr(pfsr_pkg::CSR_PREAMBLE, 32'h00FF_00FF);
      push_csr(pfsr_pkg::CSR_PREAMBLE_LEN, 32'd7);
      push_csr(pfsr_pkg::CSR_FRAME_BYTES, 32'd1);
      push_sync();
      push_byte(8'hC3);

      // Shortening the preamble mid-hunt completes it on the next match.
      push_csr(pfsr_pkg::CSR_PREAMBLE_LEN, 32'd4);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_csr(pfsr_pkg::CSR_PREAMBLE_LEN, 32'd2);
      push_byte(8'h00);
      push_byte(8'h81);

      // An oversized frame register saturates; a later short length closes the frame.
      push_csr(pfsr_pkg::CSR_PREAMBLE, pick_preamble());
      push_csr(pfsr_pkg::CSR_PREAMBLE_LEN, 32'd1);
      push_csr(pfsr_pkg::CSR_FRAME_BYTES, 32'h0001_FFFF);
      push_sync();
      repeat (LONG_PREFIX) push_byte(8'($urandom));
      push_csr(pfsr_pkg::CSR_FRAME_BYTES, 32'd5);
      push_byte(8'($urandom));

      // Random phases: new settings, then frames with noise and broken syncs.
      first_random = queued_bytes;
      while (queued_bytes - first_random < RANDOM_BYTES) begin
         if ($urandom_range(0, 3) != 0)
            push_csr(pfsr_pkg::CSR_PREAMBLE, pick_preamble());
         if ($urandom_range(0, 2) != 0)
            push_csr(pfsr_pkg::CSR_PREAMBLE_LEN, $urandom_range(0, 7));
         if ($urandom_range(0, 2) != 0)
            push_csr(pfsr_pkg::CSR_FRAME_BYTES, 32'(pick_frame()));
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
            if ($urandom_range(0, 3) == 0) begin
               k = $urandom_range(0, sync_len(gen_cfg.pre_len) - 1);
               for (int i = 0; i < k; i++) push_byte(sync_byte(gen_cfg, i));
               b = sync_byte(gen_cfg, k) ^ 8'($urandom_range(1, 255));
               push_byte(b);
            end
            push_sync();
            len = frame_len(gen_cfg.frame_len);
            // Now and then cut a frame short so the next writes land mid-frame.
            if ($urandom_range(0, 7) == 0) len = $urandom_range(0, len);
            repeat (len) push_byte(8'($urandom));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
      end while (link_ops.size() != 0 || req_tvalid || expected_payload.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_payload.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
